FILE: rtl/jst_pkg.sv
package jst_pkg;

  localparam int SLOTS_DEF = 16;   // default table depth
  localparam int MAX_LIST  = 16;   // most results one list transaction returns
  localparam int LIST_CNT_W = $clog2(MAX_LIST + 1);

  localparam int PID_W  = 22;
  localparam int JID_W  = 17;
  localparam int JST_W  = 2;
  localparam int SLOT_W = 4;

  // operation codes
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_SET    = 3'd2;
  localparam logic [2:0] KIND_LOOKUP = 3'd3;
  localparam logic [2:0] KIND_FG     = 3'd4;
  localparam logic [2:0] KIND_LIST   = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_MATCH = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_BAD_PID  = 2'd3;

  localparam logic [JST_W-1:0] JOB_FG   = 2'd1;
  localparam logic [JID_W-1:0] JID_MAX  = 17'h1FFFF;
  localparam logic [JID_W:0]   JID_WRAP = 18'd65536;

  typedef struct packed {
    logic [2:0]       kind;
    logic [PID_W-1:0] proc_id;
    logic [JST_W-1:0] new_state;
  } jst_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PID_W-1:0]  out_pid;
    logic [JID_W-1:0]  out_jid;
    logic [JST_W-1:0]  out_state;
    logic [SLOT_W-1:0] out_slot;
    logic              last;
  } jst_out_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [JID_W-1:0] jid;
    logic [JST_W-1:0] state;
  } jst_entry_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } jst_fsm_t;

endpackage

FILE: rtl/job_slot_table.sv
// Channel  Direction  Ports                          Payload
// in       input      in_valid, in_ready, in_data    jst_in_t  (kind, proc_id, new_state)
// out      output     out_valid, out_ready, out_data jst_out_t (status, pid, jid, state,
//                                                              slot, last)
//
// One operation at a time: the next accept waits for the current operation to finish
// its scan of the single-port slot memory, read one slot a cycle unless the scan is held.
// Every cycle a list result or a final result waits on a result not yet taken by
// out_ready holds the scan or the completion step.
// Reset (rst_n, synchronous, active low) clears the per-slot occupied bits at once,
// so the table reads empty on the first cycle after reset; no clearing pass.
// The output register frees the input side: a new transaction is taken while a
// result still waits for out_ready.
module job_slot_table import jst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jst_out_t out_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOTS);

  // ---------------------------------------------------------------------------
  // Slot memory: pid, job id and state of each slot. An entry is only meaningful
  // while its occupied bit is set; otherwise it reads as all zero.
  // ---------------------------------------------------------------------------
  jst_entry_t slot_mem [SLOTS];
  jst_entry_t rd_q_r;
  logic             mem_rd_en;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_idx;
  jst_entry_t       mem_wr_data;

  // control state
  jst_fsm_t              state_r, state_nxt;
  logic [SLOTS-1:0]      occ_r, occ_nxt;
  logic [JID_W-1:0]      next_id_r, next_id_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;      // next slot to read
  logic                  b_valid_r, b_valid_nxt;    // read data for b_idx_r present
  logic                  hit_r, hit_nxt;
  logic [LIST_CNT_W-1:0] cnt_r, cnt_nxt;            // list results sent so far
  logic                  out_valid_r, out_valid_nxt;

  // payload state
  jst_in_t          op_r, op_nxt;
  logic [IDX_W-1:0] b_idx_r, b_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  jst_entry_t       hit_ent_r, hit_ent_nxt;
  logic [JID_W-1:0] max_r, max_nxt;                 // largest jid outside the first hit
  jst_out_t         out_r, out_nxt;

  // scan datapath
  logic       occ_b;
  jst_entry_t b_ent;
  logic       b_match;
  logic       list_emit;
  logic       more_after;
  logic       out_free;
  logic       scan_stall;

  // completion datapath
  logic             pid_op;
  logic             need_out;
  logic             wr_pre;
  logic             occ_set_pre;
  logic             occ_clr_pre;
  logic [JID_W:0]   id_sum;
  logic [JID_W-1:0] id_sat;
  jst_entry_t       new_ent;
  jst_out_t         done_res;

  function automatic logic [SLOT_W-1:0] slot_lo(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  function automatic jst_out_t mk_res(input logic [1:0] status, input jst_entry_t ent,
                                      input logic [SLOT_W-1:0] slot, input logic last);
    jst_out_t r;
    r.status    = status;
    r.out_pid   = ent.pid;
    r.out_jid   = ent.jid;
    r.out_state = ent.state;
    r.out_slot  = slot;
    r.last      = last;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_q_r <= slot_mem[rd_idx_r[IDX_W-1:0]];
    end
    if (mem_wr_en) begin
      slot_mem[mem_wr_idx] <= mem_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan stage: the slot read last cycle is classified here. Writes only happen
  // in FSM_DONE, after the scan has drained, so no read sees a pending write.
  // ---------------------------------------------------------------------------
  assign occ_b = occ_r[b_idx_r];
  assign b_ent = occ_b ? rd_q_r : '0;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (op_r.kind)
      KIND_ADD:    b_match = !occ_b;
      KIND_DELETE,
      KIND_SET,
      KIND_LOOKUP: b_match = occ_b && (b_ent.pid == op_r.proc_id);
      KIND_FG:     b_match = occ_b && (b_ent.state == JOB_FG);
      KIND_LIST:   b_match = occ_b;
      default:     b_match = 1'b0;
    endcase
  end

  // last flag of a list result: no occupied slot further on, or the cap is reached
  assign more_after = |(occ_r & (({SLOTS{1'b1}} << b_idx_r) << 1));
  assign list_emit  = (state_r == FSM_SCAN) && b_valid_r && (op_r.kind == KIND_LIST) &&
                      occ_b && (cnt_r != LIST_CNT_W'(MAX_LIST));
  assign scan_stall = list_emit && !out_free;

  // ---------------------------------------------------------------------------
  // Completion: result of the single-result operations and the write-back.
  // ---------------------------------------------------------------------------
  assign pid_op = (op_r.kind == KIND_ADD) || (op_r.kind == KIND_DELETE) ||
                  (op_r.kind == KIND_SET) || (op_r.kind == KIND_LOOKUP);

  assign id_sum = {1'b0, next_id_r} + {{JID_W{1'b0}}, 1'b1};
  assign id_sat = (id_sum > {1'b0, JID_MAX}) ? JID_MAX : id_sum[JID_W-1:0];

  always_comb begin
    need_out    = 1'b1;
    wr_pre      = 1'b0;
    occ_set_pre = 1'b0;
    occ_clr_pre = 1'b0;
    new_ent     = hit_ent_r;
    done_res    = mk_res(STAT_NO_MATCH, '0, '0, 1'b1);
    if (pid_op && (op_r.proc_id == '0)) begin
      done_res = mk_res(STAT_BAD_PID, '0, '0, 1'b1);
    end else begin
      case (op_r.kind)
        KIND_ADD: begin
          new_ent = '{pid: op_r.proc_id, jid: id_sat, state: op_r.new_state};
          if (hit_r) begin
            wr_pre      = 1'b1;
            occ_set_pre = 1'b1;
            done_res    = mk_res(STAT_OK, new_ent, slot_lo(hit_idx_r), 1'b1);
          end else begin
            done_res = mk_res(STAT_FULL, '0, '0, 1'b1);
          end
        end
        KIND_DELETE: begin
          if (hit_r) begin
            occ_clr_pre = 1'b1;
            done_res    = mk_res(STAT_OK, hit_ent_r, slot_lo(hit_idx_r), 1'b1);
          end
        end
        KIND_SET: begin
          new_ent.state = op_r.new_state;
          if (hit_r) begin
            wr_pre   = 1'b1;
            done_res = mk_res(STAT_OK, new_ent, slot_lo(hit_idx_r), 1'b1);
          end
        end
        KIND_LOOKUP,
        KIND_FG: begin
          if (hit_r) begin
            done_res = mk_res(STAT_OK, hit_ent_r, slot_lo(hit_idx_r), 1'b1);
          end
        end
        KIND_LIST: begin
          // results already went out during the scan; empty table reports no match
          need_out = (cnt_r == '0);
        end
        default: begin
          need_out = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes a transaction, SCAN walks every slot, DONE commits.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    next_id_nxt   = next_id_r;
    rd_idx_nxt    = rd_idx_r;
    b_valid_nxt   = b_valid_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    b_idx_nxt     = b_idx_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    max_nxt       = max_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    mem_rd_en     = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_idx    = hit_idx_r;
    mem_wr_data   = new_ent;

    case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt = in_data;
          // unknown kinds are taken and dropped without a result
          if (in_data.kind <= KIND_LIST) begin
            state_nxt   = FSM_SCAN;
            rd_idx_nxt  = '0;
            b_valid_nxt = 1'b0;
            hit_nxt     = 1'b0;
            cnt_nxt     = '0;
            max_nxt     = '0;
          end
        end
      end

      FSM_SCAN: begin
        if (!scan_stall) begin
          if (rd_idx_r != SCAN_END) begin
            mem_rd_en   = 1'b1;
            rd_idx_nxt  = rd_idx_r + CNT_W'(1);
            b_idx_nxt   = rd_idx_r[IDX_W-1:0];
            b_valid_nxt = 1'b1;
          end else begin
            b_valid_nxt = 1'b0;
          end
          if (b_valid_r) begin
            if (b_match && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = b_idx_r;
              hit_ent_nxt = b_ent;
            end else if (occ_b && (b_ent.jid > max_r)) begin
              max_nxt = b_ent.jid;
            end
            if (list_emit) begin
              out_valid_nxt = 1'b1;
              out_nxt = mk_res(STAT_OK, b_ent, slot_lo(b_idx_r),
                               !more_after || (cnt_r == LIST_CNT_W'(MAX_LIST - 1)));
              cnt_nxt = cnt_r + LIST_CNT_W'(1);
            end
          end else if (rd_idx_r == SCAN_END) begin
            state_nxt = FSM_DONE;
          end
        end
      end

      FSM_DONE: begin
        if (!need_out || out_free) begin
          state_nxt = FSM_IDLE;
          mem_wr_en = wr_pre;
          if (need_out) begin
            out_valid_nxt = 1'b1;
            out_nxt       = done_res;
          end
          if (occ_set_pre) begin
            occ_nxt[hit_idx_r] = 1'b1;
            next_id_nxt = ({1'b0, id_sat} > JID_WRAP) ? JID_W'(1) : id_sat;
          end
          if (occ_clr_pre) begin
            occ_nxt[hit_idx_r] = 1'b0;
            next_id_nxt = max_r;
          end
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      occ_r       <= '0;
      next_id_r   <= '0;
      rd_idx_r    <= '0;
      b_valid_r   <= 1'b0;
      hit_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      next_id_r   <= next_id_nxt;
      rd_idx_r    <= rd_idx_nxt;
      b_valid_r   <= b_valid_nxt;
      hit_r       <= hit_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    b_idx_r   <= b_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_ent_r <= hit_ent_nxt;
    max_r     <= max_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // write-back only after the scan has drained: no read can race a write
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == FSM_DONE))
    else $error("slot memory written outside completion");

  assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (state_r == FSM_SCAN))
    else $error("scan data present outside scan");

  // every successful result names an occupied slot
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STAT_OK)) |-> (out_data.out_pid != '0))
    else $error("ok result with empty pid");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STAT_OK)) |-> (out_data.last && (out_data.out_jid == '0)))
    else $error("error result not final or carries a job id");

  // a list scan never sends more results than the cap
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIST_CNT_W'(MAX_LIST))
    else $error("list result count over cap");
`endif

endmodule
